FILE: rtl/core/brmf_pkg.sv
// ============================================================================
// brmf_pkg
// Shared types and constants for the occupancy bitmap block: payload structs,
// action codes and the job descriptor passed from front to back.
// ============================================================================
package brmf_pkg;

    // Default geometry of the bitmap
    localparam int TOTAL_BITS_DEF = 4096;
    localparam int WORD_BITS_DEF  = 32;

    // Field widths of the item and the result
    localparam int START_W = 12;
    localparam int COUNT_W = 13;
    localparam int POS_W   = 12;

    // Bit index width: start + count reaches 12286 before clipping
    localparam int IDX_W = 14;

    // Depth of the job queue between front and back
    localparam int Q_DEPTH = 2;

    typedef enum logic [1:0] {
        ACT_MARK   = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_UNUSED = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        JOB_MARK   = 2'd0,
        JOB_FREE   = 2'd1,
        JOB_SEARCH = 2'd2,
        JOB_NONE   = 2'd3
    } t_job_op;

    typedef struct packed {
        t_action              action;
        logic [START_W-1:0]   start_req;
        logic [COUNT_W-1:0]   count;
    } t_in;

    typedef struct packed {
        logic                 found;
        logic [POS_W-1:0]     position;
    } t_out;

    // Clipped bit range [lo, hi) and the word that holds bit lo
    typedef struct packed {
        t_job_op              op;
        logic [IDX_W-1:0]     lo;
        logic [IDX_W-1:0]     hi;
        logic [IDX_W-1:0]     word;
    } t_job;

endpackage

FILE: rtl/core/brmf_ram.sv
// ============================================================================
// brmf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module brmf_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 128,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/brmf_front.sv
// ============================================================================
// brmf_front
// Classifies an incoming item: clips its range to the capacity, finds the
// first word it touches and turns empty or unused requests into no-op jobs.
// ============================================================================
module brmf_front
    import brmf_pkg::*;
#(
    parameter int TOTAL_BITS = TOTAL_BITS_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
) (
    input  t_in  i_item,
    output t_job o_job
);
    // Capacity as a bit index, never above what IDX_W can hold
    localparam int CAP = (TOTAL_BITS < (2**IDX_W - 1)) ? TOTAL_BITS : (2**IDX_W - 1);
    localparam logic [IDX_W-1:0] CAP_V = IDX_W'(CAP);

    // Exact reciprocal for start / WORD_BITS over all START_W-bit starts
    localparam int DIV_SH = START_W + $clog2(WORD_BITS);
    localparam int DIV_M  = (2**DIV_SH + WORD_BITS - 1) / WORD_BITS;
    localparam int MUL_W  = START_W + DIV_SH + 2;

    logic [IDX_W-1:0] start_ix;
    logic [IDX_W-1:0] range_sum;
    logic [IDX_W-1:0] range_hi;
    logic [IDX_W-1:0] search_hi;
    logic [MUL_W-1:0] div_prod;
    logic [IDX_W-1:0] first_word;

    // Clip the range end and the search length
    assign start_ix  = IDX_W'(i_item.start_req);
    assign range_sum = start_ix + IDX_W'(i_item.count);
    assign range_hi  = (range_sum > CAP_V) ? CAP_V : range_sum;
    assign search_hi = (IDX_W'(i_item.count) > CAP_V) ? CAP_V : IDX_W'(i_item.count);

    // Word holding the first bit of the range
    assign div_prod   = MUL_W'(i_item.start_req) * MUL_W'(DIV_M);
    assign first_word = IDX_W'(div_prod >> DIV_SH);

    // Build the job
    always_comb begin
        o_job.op   = JOB_NONE;
        o_job.lo   = '0;
        o_job.hi   = '0;
        o_job.word = '0;
        unique case (i_item.action) inside
            ACT_MARK, ACT_FREE: begin
                o_job.lo   = start_ix;
                o_job.hi   = range_hi;
                o_job.word = first_word;
                if (start_ix < range_hi) begin
                    o_job.op = (i_item.action == ACT_MARK) ? JOB_MARK : JOB_FREE;
                end
            end
            ACT_SEARCH: begin
                o_job.hi = search_hi;
                if (search_hi != '0) begin
                    o_job.op = JOB_SEARCH;
                end
            end
            default: begin
                o_job.op = JOB_NONE;
            end
        endcase
    end

endmodule

FILE: rtl/core/brmf_queue.sv
// ============================================================================
// brmf_queue
// Short job queue between front and back so that each side stalls alone.
// ============================================================================
module brmf_queue
    import brmf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    output logic o_valid,
    output t_job o_data,
    input  logic i_pop
);
    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_job             r_slot [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_slot[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Store pushed job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/core/brmf_back.sv
// ============================================================================
// brmf_back
// Executes jobs on the bitmap memory one word per cycle: read-modify-write
// for mark and free, lowest-clear-bit scan for search. Clears the memory
// after reset and holds the result in an output register.
// ============================================================================
module brmf_back
    import brmf_pkg::*;
#(
    parameter int TOTAL_BITS = TOTAL_BITS_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    input  t_job i_job,
    output logic o_job_pop,
    output logic o_clearing,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);
    localparam int WORD_COUNT = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int OFF_W      = $clog2(WORD_BITS + 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_EXEC  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic                 r_out_valid, n_out_valid;
    t_job_op              r_op, n_op;
    logic [IDX_W-1:0]     r_lo, n_lo;
    logic [IDX_W-1:0]     r_hi, n_hi;
    logic [IDX_W-1:0]     r_base, n_base;
    logic                 r_found, n_found;
    logic [POS_W-1:0]     r_pos, n_pos;
    t_out                 r_out, n_out;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [IDX_W-1:0]     base_end;
    logic                 last_word;
    logic [OFF_W-1:0]     lo_off;
    logic [OFF_W-1:0]     hi_off;
    logic [WORD_BITS-1:0] range_mask;
    logic [WORD_BITS-1:0] clear_bits;
    logic                 clear_any;
    logic [OFF_W-1:0]     clear_idx;

    brmf_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Part of the current word that lies inside [lo, hi)
    assign base_end  = r_base + IDX_W'(WORD_BITS);
    assign last_word = (r_hi <= base_end);
    assign lo_off    = (r_lo > r_base) ? OFF_W'(r_lo - r_base) : '0;
    assign hi_off    = last_word ? OFF_W'(r_hi - r_base) : OFF_W'(WORD_BITS);

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            range_mask[j] = (OFF_W'(j) >= lo_off) && (OFF_W'(j) < hi_off);
        end
    end

    // Lowest clear bit inside the range
    assign clear_bits = ~ram_rdata & range_mask;

    always_comb begin
        clear_any = 1'b0;
        clear_idx = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (clear_bits[j]) begin
                clear_any = 1'b1;
                clear_idx = OFF_W'(j);
            end
        end
    end

    // Sequence one job at a time
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_base      = r_base;
        n_found     = r_found;
        n_pos       = r_pos;
        n_out       = r_out;
        o_job_pop   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = r_addr;

        // Drop the result once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                if (r_addr == ADDR_W'(WORD_COUNT - 1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_op      = i_job.op;
                    n_lo      = i_job.lo;
                    n_hi      = i_job.hi;
                    n_addr    = ADDR_W'(i_job.word);
                    n_base    = IDX_W'(i_job.word * IDX_W'(WORD_BITS));
                    n_found   = 1'b0;
                    n_pos     = '0;
                    n_state   = (i_job.op == JOB_NONE) ? S_DONE : S_READ;
                end
            end
            S_READ: begin
                ram_re  = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (r_op == JOB_MARK) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | range_mask;
                end else if (r_op == JOB_FREE) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata & ~range_mask;
                end
                if (r_op == JOB_SEARCH && clear_any) begin
                    n_found = 1'b1;
                    n_pos   = POS_W'(r_base + IDX_W'(clear_idx));
                    n_state = S_DONE;
                end else if (last_word) begin
                    n_state = S_DONE;
                end else begin
                    // Fetch the next word while this one is written back
                    n_addr    = r_addr + 1'b1;
                    n_base    = base_end;
                    ram_re    = 1'b1;
                    ram_raddr = r_addr + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.found    = r_found;
                    n_out.position = r_pos;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_base  <= n_base;
        r_found <= n_found;
        r_pos   <= n_pos;
        r_out   <= n_out;
    end

    assign o_clearing  = (r_state == S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/core/bitmap_range_mark_and_free_search_top.sv
// ============================================================================
// bitmap_range_mark_and_free_search_top
// Occupancy bitmap with range mark, range free and first-clear-bit search.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one request:
//   mark a range, free a range, or search the lowest clear bit among the
//   first count bits. Output channel (o_out_valid / i_out_ready / o_out_data)
//   returns exactly one result per request, in request order.
//   After reset the bitmap memory is zeroed one word per cycle, over
//   TOTAL_BITS / WORD_BITS words (rounded up, 128 at the defaults), and
//   o_in_ready stays low until it is done.
//   The front clips the range and queues a job (Q_DEPTH entries); the back
//   walks the bitmap memory one word per cycle. A job passes through pop,
//   read, one read-modify-write or scan step per word, and result hand-off;
//   a search stops at the first word with a clear bit; an empty range or
//   unused action goes from pop straight to result hand-off.
//   While the receiver stalls, the result holds in the output register, the
//   back finishes the next job, and the queue keeps taking requests until full.
// ============================================================================
module bitmap_range_mark_and_free_search_top
    import brmf_pkg::*;
#(
    parameter int TOTAL_BITS = TOTAL_BITS_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);
    t_job front_job;
    t_job queue_job;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;
    logic clearing;
    logic in_push;

    // Accept while the queue has room and the memory is not being cleared
    assign o_in_ready = !queue_full && !clearing;
    assign in_push    = i_in_valid && o_in_ready;

    brmf_front #(
        .TOTAL_BITS (TOTAL_BITS),
        .WORD_BITS  (WORD_BITS)
    ) u_front (
        .i_item (i_in_data),
        .o_job  (front_job)
    );

    brmf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_push),
        .i_data  (front_job),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_data  (queue_job),
        .i_pop   (queue_pop)
    );

    brmf_back #(
        .TOTAL_BITS (TOTAL_BITS),
        .WORD_BITS  (WORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .i_job       (queue_job),
        .o_job_pop   (queue_pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: rtl/core/brmf_checker.sv
// ============================================================================
// brmf_checker
// Port-level checks for the occupancy bitmap block, bound to the top level.
// ============================================================================
module brmf_checker
    import brmf_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // Reset drops any pending result
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Reset starts the memory clear, so no request is taken next cycle
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("request accepted before memory clear");

endmodule

bind bitmap_range_mark_and_free_search_top brmf_checker u_brmf_checker (.*);
